// ----- rtl/mke_pkg.sv -----
// Shared types, constants and lookup tables for the Morse keying encoder.
`timescale 1ns / 1ps

package mke_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHAR,
    S_ELEM_ON,
    S_ELEM_OFF,
    S_SPACE,
    S_GAP,
    S_CMD_VAL,
    S_CMD_EXEC,
    S_CMD_OFF,
    S_FLUSH
  } state_t;

  // Which segment the datapath builds on an emit
  typedef enum logic [2:0] {
    EM_ELEM,   // dot or dash, key on
    EM_UNIT,   // key off for t
    EM_TWO,    // key off for 2t
    EM_SIX,    // key off for 6t
    EM_TONE,   // key on, command time
    EM_PAUSE   // key off, command time
  } emit_sel_t;

  // Captured command letter
  typedef enum logic [1:0] {
    CK_NONE,
    CK_TONE,
    CK_PAUSE,
    CK_SPEED
  } cmd_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    logic      decode;
    logic      char_load;
    logic      emit;
    emit_sel_t emit_sel;
    logic      shift;
    logic      rep_next;
    logic      val_load;
    logic      wpm_load;
    logic      flush;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic      emit_ok;
    logic      ignore;
    logic      cap_open;
    logic      cap_last;
    logic      cap_cmd;
    logic      open_brace;
    logic      ch_space;
    logic      ch_pulses;
    logic      elem_left;
    logic      join_on;
    logic      rep_more;
    cmd_kind_t cmd_kind;
  } dp_stat_t;

  // Character codes
  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_LT     = 8'h3C;
  localparam logic [7:0] CHR_GT     = 8'h3E;
  localparam logic [7:0] CHR_P      = 8'h50;
  localparam logic [7:0] CHR_T      = 8'h54;
  localparam logic [7:0] CHR_W      = 8'h57;
  localparam logic [7:0] CHR_LOWER  = 8'h61;
  localparam logic [7:0] CHR_LBRACE = 8'h7B;
  localparam logic [7:0] CHR_RBRACE = 8'h7D;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Pattern table covers 0x20..0x5B; anything else maps to the blank entry
  localparam logic [7:0] TAB_FIRST = 8'h20;
  localparam logic [7:0] TAB_END   = 8'h5B;
  localparam logic [5:0] TAB_BLANK = 6'd59;

  localparam logic [5:0]  MAX_SEGS     = 6'd53;
  localparam logic [7:0]  DEFAULT_TIME = 8'd60;
  localparam logic [16:0] CMD_MS_SCALE = 17'd1000;
  localparam logic [16:0] CMD_MS_BIAS  = 17'd100;

  // Element bits, MSB-first at bit 6 (1 = dash)
  localparam logic [6:0] PAT_BITS [60] = '{
    7'h00, 7'h18, 7'h24, 7'h00, 7'h00, 7'h00, 7'h00, 7'h3C, 7'h5A, 7'h5A,
    7'h00, 7'h00, 7'h66, 7'h42, 7'h2A, 7'h48, 7'h7C, 7'h3C, 7'h1C, 7'h0C,
    7'h04, 7'h00, 7'h40, 7'h60, 7'h70, 7'h78, 7'h70, 7'h00, 7'h00, 7'h44,
    7'h00, 7'h18, 7'h00, 7'h20, 7'h40, 7'h50, 7'h40, 7'h00, 7'h10, 7'h60,
    7'h00, 7'h00, 7'h38, 7'h50, 7'h20, 7'h60, 7'h40, 7'h70, 7'h30, 7'h68,
    7'h20, 7'h00, 7'h40, 7'h10, 7'h08, 7'h30, 7'h48, 7'h58, 7'h60, 7'h00
  };

  // Number of elements per character
  localparam logic [2:0] PAT_LEN [60] = '{
    3'd0, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd6, 3'd6, 3'd6,
    3'd0, 3'd0, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd0, 3'd0, 3'd5,
    3'd0, 3'd6, 3'd0, 3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3,
    3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4,
    3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd0
  };

  // Element time in ms: 1200/wpm for 5..50 wpm, otherwise 60
  function automatic logic [7:0] element_time_for(input logic [7:0] wpm);
    logic [7:0] t;
    case (wpm)
      8'd5:  t = 8'd240;
      8'd6:  t = 8'd200;
      8'd7:  t = 8'd171;
      8'd8:  t = 8'd150;
      8'd9:  t = 8'd133;
      8'd10: t = 8'd120;
      8'd11: t = 8'd109;
      8'd12: t = 8'd100;
      8'd13: t = 8'd92;
      8'd14: t = 8'd85;
      8'd15: t = 8'd80;
      8'd16: t = 8'd75;
      8'd17: t = 8'd70;
      8'd18: t = 8'd66;
      8'd19: t = 8'd63;
      8'd20: t = 8'd60;
      8'd21: t = 8'd57;
      8'd22: t = 8'd54;
      8'd23: t = 8'd52;
      8'd24: t = 8'd50;
      8'd25: t = 8'd48;
      8'd26: t = 8'd46;
      8'd27: t = 8'd44;
      8'd28: t = 8'd42;
      8'd29: t = 8'd41;
      8'd30: t = 8'd40;
      8'd31: t = 8'd38;
      8'd32: t = 8'd37;
      8'd33: t = 8'd36;
      8'd34: t = 8'd35;
      8'd35: t = 8'd34;
      8'd36: t = 8'd33;
      8'd37: t = 8'd32;
      8'd38: t = 8'd31;
      8'd39: t = 8'd30;
      8'd40: t = 8'd30;
      8'd41: t = 8'd29;
      8'd42: t = 8'd28;
      8'd43: t = 8'd27;
      8'd44: t = 8'd27;
      8'd45: t = 8'd26;
      8'd46: t = 8'd26;
      8'd47: t = 8'd25;
      8'd48: t = 8'd25;
      8'd49: t = 8'd24;
      8'd50: t = 8'd24;
      default: t = DEFAULT_TIME;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/mke_dp.sv -----
// Datapath of the Morse keying encoder: capture, pattern, timing and output registers.
`timescale 1ns / 1ps

module mke_dp (
  input  logic              clk,
  input  logic              rst,
  input  mke_pkg::dp_cmd_t  cmd,
  output mke_pkg::dp_stat_t stat,
  input  logic [7:0]        text_byte,
  input  logic              cfg_we,
  input  logic [7:0]        start_wpm,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              key_on,
  output logic [16:0]       duration_ms,
  output logic              last
);

  logic [7:0]  in_byte;
  logic [7:0]  elem_time;
  logic        join_on;
  logic [2:0]  cap_cnt;
  logic [7:0]  cap_bytes [4];
  logic        replay;
  logic [2:0]  rep_idx;
  logic [6:0]  pat_bits;
  logic [2:0]  pat_len;
  logic [6:0]  val;
  logic [5:0]  emit_cnt;
  logic        pend_valid;
  logic        pend_on;
  logic [16:0] pend_dur;

  logic [2:0]  rep_pos;
  logic [2:0]  cap_pos;
  logic [7:0]  src;
  logic [7:0]  folded;
  logic [7:0]  tab_off;
  logic [5:0]  tab_idx;
  logic [7:0]  hi_off;
  logic [7:0]  lo_off;
  logic        digits_ok;
  logic [6:0]  val_c;
  logic        new_on;
  logic [16:0] new_dur;
  logic [16:0] cmd_ms;
  logic        out_free;
  logic        emit_take;
  logic        push;

  // Character source: direct byte, or the replay of a failed capture
  assign rep_pos = rep_idx - 3'd1;
  always_comb begin
    if (!replay) begin
      src = in_byte;
    end else if (rep_idx == 3'd0) begin
      src = mke_pkg::CHR_LBRACE;
    end else begin
      src = cap_bytes[rep_pos[1:0]];
    end
  end

  // Case fold and table index
  assign folded  = (src >= mke_pkg::CHR_LOWER) ? src - mke_pkg::CASE_OFFSET : src;
  assign tab_off = folded - mke_pkg::TAB_FIRST;
  assign tab_idx = (folded >= mke_pkg::TAB_FIRST && folded <= mke_pkg::TAB_END) ?
                   tab_off[5:0] : mke_pkg::TAB_BLANK;

  // Capture slot for the current byte
  assign cap_pos = cap_cnt - 3'd1;

  // Command value from two ASCII digits
  assign hi_off    = cap_bytes[1] - mke_pkg::CHR_ZERO;
  assign lo_off    = cap_bytes[2] - mke_pkg::CHR_ZERO;
  assign digits_ok = (cap_bytes[1] >= mke_pkg::CHR_ZERO) && (cap_bytes[1] <= mke_pkg::CHR_NINE) &&
                     (cap_bytes[2] >= mke_pkg::CHR_ZERO) && (cap_bytes[2] <= mke_pkg::CHR_NINE);
  assign val_c     = 7'({3'b000, hi_off[3:0]} * 7'd10) + {3'b000, lo_off[3:0]};
  assign cmd_ms    = 17'(val) * mke_pkg::CMD_MS_SCALE + mke_pkg::CMD_MS_BIAS;

  // Segment builder
  always_comb begin
    new_on  = 1'b0;
    new_dur = '0;
    case (cmd.emit_sel)
      mke_pkg::EM_ELEM: begin
        new_on  = 1'b1;
        new_dur = pat_bits[6] ? 17'(elem_time) * 17'd3 : 17'(elem_time);
      end
      mke_pkg::EM_UNIT:  new_dur = 17'(elem_time);
      mke_pkg::EM_TWO:   new_dur = {8'd0, elem_time, 1'b0};
      mke_pkg::EM_SIX:   new_dur = 17'(elem_time) * 17'd6;
      mke_pkg::EM_TONE: begin
        new_on  = 1'b1;
        new_dur = cmd_ms;
      end
      mke_pkg::EM_PAUSE: new_dur = cmd_ms;
      default: new_dur = '0;
    endcase
  end

  // One segment is held back so the final one can carry last
  assign out_free  = !out_valid || !out_stall;
  assign emit_take = cmd.emit && (emit_cnt < mke_pkg::MAX_SEGS);
  assign push      = pend_valid && (emit_take || cmd.flush);

  // Status to the controller
  always_comb begin
    stat.emit_ok    = !pend_valid || out_free;
    stat.ignore     = (in_byte == mke_pkg::CHR_NUL) || (in_byte == mke_pkg::CHR_LF);
    stat.cap_open   = cap_cnt != 3'd0;
    stat.cap_last   = cap_pos[1:0] == 2'd3;
    stat.cap_cmd    = in_byte == mke_pkg::CHR_RBRACE;
    stat.open_brace = in_byte == mke_pkg::CHR_LBRACE;
    stat.ch_space   = folded == mke_pkg::CHR_SPACE;
    stat.ch_pulses  = mke_pkg::PAT_LEN[tab_idx] != 3'd0;
    stat.elem_left  = pat_len != 3'd0;
    stat.join_on    = join_on;
    stat.rep_more   = replay && (rep_idx != 3'd4);
    if (cap_bytes[0] == mke_pkg::CHR_T) begin
      stat.cmd_kind = mke_pkg::CK_TONE;
    end else if (cap_bytes[0] == mke_pkg::CHR_P) begin
      stat.cmd_kind = mke_pkg::CK_PAUSE;
    end else if (cap_bytes[0] == mke_pkg::CHR_W) begin
      stat.cmd_kind = mke_pkg::CK_SPEED;
    end else begin
      stat.cmd_kind = mke_pkg::CK_NONE;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_time  <= mke_pkg::DEFAULT_TIME;
      join_on    <= 1'b0;
      cap_cnt    <= 3'd0;
      replay     <= 1'b0;
      rep_idx    <= 3'd0;
      pat_len    <= 3'd0;
      emit_cnt   <= 6'd0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        elem_time <= mke_pkg::element_time_for(start_wpm);
      end else if (cmd.wpm_load) begin
        elem_time <= mke_pkg::element_time_for({1'b0, val});
      end

      if (cmd.decode && !stat.ignore) begin
        replay  <= stat.cap_open && stat.cap_last && !stat.cap_cmd;
        rep_idx <= 3'd0;
        if (stat.cap_open) begin
          cap_cnt <= stat.cap_last ? 3'd0 : cap_cnt + 3'd1;
        end else if (stat.open_brace) begin
          cap_cnt <= 3'd1;
        end
      end else if (cmd.rep_next) begin
        rep_idx <= rep_idx + 3'd1;
      end

      if (cmd.char_load) begin
        pat_len <= mke_pkg::PAT_LEN[tab_idx];
        if (folded == mke_pkg::CHR_LT) begin
          join_on <= 1'b1;
        end else if (folded == mke_pkg::CHR_GT) begin
          join_on <= 1'b0;
        end
      end else if (cmd.shift) begin
        pat_len <= pat_len - 3'd1;
      end

      if (cmd.accept) begin
        emit_cnt <= 6'd0;
      end else if (emit_take) begin
        emit_cnt <= emit_cnt + 6'd1;
      end

      if (emit_take) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end

      out_valid <= push || (out_valid && out_stall);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_byte <= text_byte;
    end
    if (cmd.decode && !stat.ignore && stat.cap_open) begin
      cap_bytes[cap_pos[1:0]] <= in_byte;
    end
    if (cmd.char_load) begin
      pat_bits <= mke_pkg::PAT_BITS[tab_idx];
    end else if (cmd.shift) begin
      pat_bits <= {pat_bits[5:0], 1'b0};
    end
    if (cmd.val_load) begin
      val <= digits_ok ? val_c : 7'd0;
    end
    if (emit_take) begin
      pend_on  <= new_on;
      pend_dur <= new_dur;
    end
    if (push) begin
      key_on      <= pend_on;
      duration_ms <= pend_dur;
      last        <= cmd.flush;
    end
  end

  a_seg_cap: assert property (@(posedge clk) disable iff (rst)
    emit_cnt <= mke_pkg::MAX_SEGS)
    else $error("segment count beyond limit");

  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    cap_cnt <= 3'd4)
    else $error("capture count out of range");

  a_rep_range: assert property (@(posedge clk) disable iff (rst)
    rep_idx <= 3'd4)
    else $error("replay index out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("output register overwritten while stalled");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.flush) |-> stat.emit_ok)
    else $error("emit issued without room for the held segment");

endmodule

// ----- rtl/mke_ctrl.sv -----
// Sequencer of the Morse keying encoder: walks a byte through decode, elements and gaps, or a command.
`timescale 1ns / 1ps

module mke_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mke_pkg::dp_stat_t stat,
  output mke_pkg::dp_cmd_t  cmd,
  output logic              idle
);

  mke_pkg::state_t state;
  mke_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mke_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mke_pkg::S_IDLE: begin
        if (in_valid) state_next = mke_pkg::S_DECODE;
      end
      mke_pkg::S_DECODE: begin
        if (stat.ignore) begin
          state_next = mke_pkg::S_FLUSH;
        end else if (stat.cap_open) begin
          if (!stat.cap_last) begin
            state_next = mke_pkg::S_FLUSH;
          end else if (stat.cap_cmd) begin
            state_next = mke_pkg::S_CMD_VAL;
          end else begin
            state_next = mke_pkg::S_CHAR;
          end
        end else if (stat.open_brace) begin
          state_next = mke_pkg::S_FLUSH;
        end else begin
          state_next = mke_pkg::S_CHAR;
        end
      end
      mke_pkg::S_CHAR: begin
        if (stat.ch_space) begin
          state_next = mke_pkg::S_SPACE;
        end else if (stat.ch_pulses) begin
          state_next = mke_pkg::S_ELEM_ON;
        end else begin
          state_next = mke_pkg::S_GAP;
        end
      end
      mke_pkg::S_ELEM_ON: begin
        if (stat.emit_ok) state_next = mke_pkg::S_ELEM_OFF;
      end
      mke_pkg::S_ELEM_OFF: begin
        if (stat.emit_ok) begin
          state_next = stat.elem_left ? mke_pkg::S_ELEM_ON : mke_pkg::S_GAP;
        end
      end
      mke_pkg::S_SPACE: begin
        if (stat.emit_ok) state_next = mke_pkg::S_GAP;
      end
      mke_pkg::S_GAP: begin
        if (stat.emit_ok) begin
          state_next = stat.rep_more ? mke_pkg::S_CHAR : mke_pkg::S_FLUSH;
        end
      end
      mke_pkg::S_CMD_VAL: state_next = mke_pkg::S_CMD_EXEC;
      mke_pkg::S_CMD_EXEC: begin
        case (stat.cmd_kind)
          mke_pkg::CK_TONE: begin
            if (stat.emit_ok) state_next = mke_pkg::S_CMD_OFF;
          end
          mke_pkg::CK_PAUSE: begin
            if (stat.emit_ok) state_next = mke_pkg::S_FLUSH;
          end
          default: state_next = mke_pkg::S_FLUSH;
        endcase
      end
      mke_pkg::S_CMD_OFF: begin
        if (stat.emit_ok) state_next = mke_pkg::S_FLUSH;
      end
      mke_pkg::S_FLUSH: begin
        if (stat.emit_ok) state_next = mke_pkg::S_IDLE;
      end
      default: state_next = mke_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.emit_sel = mke_pkg::EM_UNIT;
    idle         = 1'b0;
    case (state)
      mke_pkg::S_IDLE: begin
        idle       = 1'b1;
        cmd.accept = in_valid;
      end
      mke_pkg::S_DECODE: cmd.decode = 1'b1;
      mke_pkg::S_CHAR:   cmd.char_load = 1'b1;
      mke_pkg::S_ELEM_ON: begin
        cmd.emit     = stat.emit_ok;
        cmd.shift    = stat.emit_ok;
        cmd.emit_sel = mke_pkg::EM_ELEM;
      end
      mke_pkg::S_ELEM_OFF: begin
        cmd.emit     = stat.emit_ok;
        cmd.emit_sel = mke_pkg::EM_UNIT;
      end
      mke_pkg::S_SPACE: begin
        cmd.emit     = stat.emit_ok;
        cmd.emit_sel = mke_pkg::EM_TWO;
      end
      mke_pkg::S_GAP: begin
        // letter gap is dropped while joining
        cmd.emit     = stat.emit_ok && !stat.join_on;
        cmd.emit_sel = mke_pkg::EM_TWO;
        cmd.rep_next = stat.emit_ok && stat.rep_more;
      end
      mke_pkg::S_CMD_VAL: cmd.val_load = 1'b1;
      mke_pkg::S_CMD_EXEC: begin
        case (stat.cmd_kind)
          mke_pkg::CK_TONE: begin
            cmd.emit     = stat.emit_ok;
            cmd.emit_sel = mke_pkg::EM_TONE;
          end
          mke_pkg::CK_PAUSE: begin
            cmd.emit     = stat.emit_ok;
            cmd.emit_sel = mke_pkg::EM_PAUSE;
          end
          mke_pkg::CK_SPEED: cmd.wpm_load = 1'b1;
          default: cmd.wpm_load = 1'b0;
        endcase
      end
      mke_pkg::S_CMD_OFF: begin
        cmd.emit     = stat.emit_ok;
        cmd.emit_sel = mke_pkg::EM_SIX;
      end
      mke_pkg::S_FLUSH: cmd.flush = stat.emit_ok;
      default: idle = 1'b0;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == mke_pkg::S_DECODE)
    else $error("accepted byte not decoded");

  a_decode_once: assert property (@(posedge clk) disable iff (rst)
    state == mke_pkg::S_DECODE |=> state != mke_pkg::S_DECODE)
    else $error("decode repeated for one byte");

  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> idle)
    else $error("flush did not end the byte");

endmodule

// ----- rtl/morse_keying_encoder_core.sv -----
// Top level of the Morse keying encoder: sequencer plus datapath.
// Output: the first segment of a byte is held back until the next is emitted, and the last
// leaves on the flush step; a step waits while a segment is held and the output is stalled.
// Throughput: one byte at a time; accept, decode and flush steps, plus a load per character
// and a step per segment or command stage; a failed capture replays five characters.
// Reset: element time 60 ms (20 wpm), joining off, no capture open; capture bytes not cleared.
`timescale 1ns / 1ps

module morse_keying_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        key_on,
  output logic [16:0] duration_ms,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  start_wpm
);

  mke_pkg::dp_cmd_t  cmd;
  mke_pkg::dp_stat_t stat;
  logic              idle;

  // Both input sides only transfer between bytes
  assign in_stall  = !idle;
  assign cfg_ready = idle;

  mke_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  mke_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .text_byte   (text_byte),
    .cfg_we      (cfg_valid && cfg_ready),
    .start_wpm   (start_wpm),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .key_on      (key_on),
    .duration_ms (duration_ms),
    .last        (last)
  );

endmodule
